FILE: hdl/ehr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ehr_pkg;

	localparam int CAPACITY_DEF   = 1024;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic signed [31:0] EPOCH_NONE = -32'sd1;
	localparam logic signed [31:0] EPOCH_MAX  = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic load;
	} ehr_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/ehr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ehr_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	output ehr_pkg::ehr_cmd_t   cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SEND = 1'b1;

	logic state_q;
	logic state_d;

	assign out_valid = (state_q == ST_SEND);
	assign in_ready  = (state_q == ST_IDLE) || out_ready;
	assign cmd.load  = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) begin
					state_d = ST_SEND;
				end
			end
			ST_SEND: begin
				if (cmd.load) begin
					state_d = ST_SEND;
				end else if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/ehr_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module ehr_dpath #(
	parameter int CAPACITY   = ehr_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = ehr_pkg::DATA_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ehr_pkg::ehr_cmd_t  cmd,
	input  wire logic [1:0]         opcode,
	input  wire logic [31:0]        write_data,
	input  wire logic signed [31:0] read_epoch,
	output logic [31:0]             read_data,
	output logic signed [31:0]      result_epoch,
	output logic signed [31:0]      latest_epoch,
	output logic [30:0]             oldest_epoch,
	output logic [10:0]             entry_count
);

	localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

	logic [SW-1:0] mem_q [CAPACITY];

	logic [PW-1:0]        head_q;
	logic [CW-1:0]        count_q;
	logic signed [31:0]   newest_q;
	logic                 hit_q;
	logic signed [31:0]   repoch_q;
	logic [SW-1:0]        rdata_q;

	logic signed [31:0]   ep;
	logic signed [32:0]   diff;
	logic                 hit;
	logic [PW-1:0]        latest_slot;
	logic [PW:0]          slot_raw;
	logic [PW-1:0]        slot;
	logic                 do_write;
	logic                 do_read;
	logic [31:0]          oldest_full;

	assign ep   = (read_epoch == ehr_pkg::EPOCH_NONE) ? newest_q : read_epoch;
	assign diff = {newest_q[31], newest_q} - {ep[31], ep};
	assign hit  = (ep != ehr_pkg::EPOCH_NONE) && !diff[32] && (diff < 33'(count_q));

	assign latest_slot = (head_q == '0) ? PW'(CAPACITY - 1) : head_q - 1'b1;
	assign slot_raw    = {1'b0, latest_slot} - {1'b0, diff[PW-1:0]};
	assign slot        = slot_raw[PW] ? (slot_raw[PW-1:0] + PW'(CAPACITY)) : slot_raw[PW-1:0];

	assign do_write = cmd.load && (opcode == ehr_pkg::OP_WRITE) &&
		(newest_q != ehr_pkg::EPOCH_MAX);
	assign do_read  = cmd.load && (opcode == ehr_pkg::OP_READ);

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem_q[head_q] <= write_data[SW-1:0];
		end
		if (do_read) begin
			rdata_q <= mem_q[slot];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			repoch_q <= ep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			newest_q <= ehr_pkg::EPOCH_NONE;
			hit_q    <= 1'b0;
		end else if (cmd.load) begin
			hit_q <= do_read && hit;
			if (do_write) begin
				head_q   <= (head_q == PW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
				if (count_q != CW'(CAPACITY)) begin
					count_q <= count_q + 1'b1;
				end
				newest_q <= newest_q + 32'sd1;
			end else if (opcode == ehr_pkg::OP_CLEAR) begin
				head_q   <= '0;
				count_q  <= '0;
				newest_q <= ehr_pkg::EPOCH_NONE;
			end
		end
	end

	assign oldest_full  = 32'(newest_q) - 32'(count_q) + 32'd1;
	assign oldest_epoch = (count_q == '0) ? 31'd0 : oldest_full[30:0];
	assign latest_epoch = newest_q;
	assign entry_count  = 11'(count_q);
	assign read_data    = hit_q ? 32'(rdata_q) : 32'd0;
	assign result_epoch = hit_q ? repoch_q : ehr_pkg::EPOCH_NONE;

endmodule

`default_nettype wire

FILE: hdl/epoch_indexed_history_ring.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake            Fields
// -------  -------------------  ------------------------------------------------------
// input    in_valid/in_ready    opcode, write_data, read_epoch
// output   out_valid/out_ready  read_data, result_epoch, latest_epoch, oldest_epoch,
//                               entry_count
//
// Each item yields one result item in the cycle after it is accepted.
// A new item is taken in the same cycle the pending result is taken, so an
// item can be accepted every cycle while out_ready stays high.
// The single history RAM port (one write or one registered read) sets that figure.
// Reset empties the ring at once; the RAM contents are not cleared.
// While a result is stalled, in_ready stays low and the block state holds.

module epoch_indexed_history_ring #(
	parameter int CAPACITY   = ehr_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = ehr_pkg::DATA_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         opcode,
	input  wire logic [31:0]        write_data,
	input  wire logic signed [31:0] read_epoch,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [31:0]             read_data,
	output logic signed [31:0]      result_epoch,
	output logic signed [31:0]      latest_epoch,
	output logic [30:0]             oldest_epoch,
	output logic [10:0]             entry_count
);

	ehr_pkg::ehr_cmd_t cmd;

	ehr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	ehr_dpath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.opcode       (opcode),
		.write_data   (write_data),
		.read_epoch   (read_epoch),
		.read_data    (read_data),
		.result_epoch (result_epoch),
		.latest_epoch (latest_epoch),
		.oldest_epoch (oldest_epoch),
		.entry_count  (entry_count)
	);

endmodule

`default_nettype wire
